FILE: design/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// expression must hold at every clock edge out of reset
`define ASSERT_HOLDS(lbl, ck, rn, expr, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (expr)) else $error(msg);
// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, ck, rn, expr, msg)
`define ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)
`endif
`endif

FILE: design/mti_pkg.sv
// types, tables and datapath functions of the isoline pipeline
package mti_pkg;

    localparam int AddrW    = 3;
    localparam int TBits    = 16;
    localparam int NStages  = TBits + 5;
    localparam int StInit   = 2;
    localparam int StMul    = NStages - 2;
    localparam int StOut    = NStages - 1;

    localparam logic REG_ISO_LEVEL = 1'b0;

    localparam logic [1:0] EDGE_01 = 2'd0;
    localparam logic [1:0] EDGE_12 = 2'd1;
    localparam logic [1:0] EDGE_20 = 2'd2;

    // crossed edges for each case code
    localparam logic [1:0] SEG_FIRST [8] = '{EDGE_01, EDGE_01, EDGE_12, EDGE_12,
                                            EDGE_20, EDGE_01, EDGE_20, EDGE_01};
    localparam logic [1:0] SEG_SECOND [8] = '{EDGE_01, EDGE_20, EDGE_01, EDGE_20,
                                             EDGE_12, EDGE_12, EDGE_01, EDGE_01};
    // vertices of each edge
    localparam logic [1:0] EDGE_VA [4] = '{2'd0, 2'd1, 2'd2, 2'd0};
    localparam logic [1:0] EDGE_VB [4] = '{2'd1, 2'd2, 2'd0, 2'd1};

    typedef struct packed {
        logic [2:0][31:0]       s;
        logic [2:0][2:0][31:0]  p;
        logic [2:0]             code;
    } tri_t;

    typedef struct packed {
        logic [32:0]        rem;
        logic [32:0]        den;
        logic [TBits-1:0]   q;
        logic               sat;
        logic               zro;
        logic [2:0][32:0]   d;
        logic [2:0][31:0]   pa;
    } lane_t;

    typedef struct packed {
        lane_t [1:0]    ln;
        logic [1:0]     e0;
        logic [1:0]     e1;
        logic [2:0]     code;
    } div_t;

    typedef struct packed {
        logic [1:0][2:0][31:0]  off;
        logic [1:0][2:0][31:0]  pa;
        logic [1:0]             e0;
        logic [1:0]             e1;
        logic [2:0]             code;
    } mul_t;

    typedef struct packed {
        logic [1:0][2:0][31:0]  pt;
        logic [1:0]             e0;
        logic [1:0]             e1;
        logic [2:0]             code;
    } seg_t;

    // magnitude of a 33-bit difference
    function automatic logic [32:0] abs33(input logic [32:0] x);
        return x[32] ? 33'(-x) : x;
    endfunction

    // 33-bit difference of two 32-bit signed values
    function automatic logic [32:0] sub33(input logic [31:0] a, input logic [31:0] b);
        return {a[31], a} - {b[31], b};
    endfunction

    // pick the edges and form numerator, denominator and coordinate deltas
    function automatic div_t edge_setup(input tri_t x, input logic [31:0] lvl);
        div_t r;
        logic [1:0] eg;
        logic [1:0] a;
        logic [1:0] b;
        r = '0;
        r.code = x.code;
        r.e0 = SEG_FIRST[x.code];
        r.e1 = SEG_SECOND[x.code];
        for (int e = 0; e < 2; e++) begin
            eg = (e == 0) ? r.e0 : r.e1;
            a = EDGE_VA[eg];
            b = EDGE_VB[eg];
            r.ln[e].rem = abs33(sub33(lvl, x.s[a]));
            r.ln[e].den = abs33(sub33(x.s[b], x.s[a]));
            for (int j = 0; j < 3; j++) begin
                r.ln[e].d[j] = sub33(x.p[b][j], x.p[a][j]);
                r.ln[e].pa[j] = x.p[a][j];
            end
        end
        return r;
    endfunction

    // saturation and zero checks ahead of the quotient bits
    function automatic div_t div_init(input div_t x);
        div_t r;
        r = x;
        for (int e = 0; e < 2; e++) begin
            r.ln[e].zro = (x.ln[e].den == '0);
            r.ln[e].sat = !r.ln[e].zro && (x.ln[e].rem >= x.ln[e].den);
            r.ln[e].q = '0;
            if (r.ln[e].zro || r.ln[e].sat)
            begin
                r.ln[e].rem = '0;
            end
        end
        return r;
    endfunction

    // one restoring division step per lane
    function automatic div_t div_step(input div_t x);
        div_t r;
        logic [33:0] r2;
        logic ge;
        r = x;
        for (int e = 0; e < 2; e++) begin
            r2 = {x.ln[e].rem, 1'b0};
            ge = (r2 >= {1'b0, x.ln[e].den});
            r.ln[e].rem = ge ? 33'(r2 - {1'b0, x.ln[e].den}) : r2[32:0];
            r.ln[e].q = {x.ln[e].q[TBits-2:0], ge};
        end
        return r;
    endfunction

    // interpolation offsets t*d, floored to Q16.16
    function automatic mul_t interp_mul(input div_t x);
        mul_t r;
        logic [TBits-1:0] t;
        logic signed [TBits+33:0] prod;
        r.e0 = x.e0;
        r.e1 = x.e1;
        r.code = x.code;
        for (int e = 0; e < 2; e++) begin
            t = x.ln[e].sat ? '1 : (x.ln[e].zro ? '0 : x.ln[e].q);
            for (int j = 0; j < 3; j++) begin
                prod = $signed({1'b0, t}) * $signed(x.ln[e].d[j]);
                r.off[e][j] = prod[TBits+31:TBits];
                r.pa[e][j] = x.ln[e].pa[j];
            end
        end
        return r;
    endfunction

endpackage

FILE: design/mti_ifs.sv
// stream interfaces for triangles in and segments out
interface mti_tri_if;
    logic        valid;
    logic        ready;
    logic [31:0] scalar_v0;
    logic [31:0] scalar_v1;
    logic [31:0] scalar_v2;
    logic [31:0] v0_x;
    logic [31:0] v0_y;
    logic [31:0] v0_z;
    logic [31:0] v1_x;
    logic [31:0] v1_y;
    logic [31:0] v1_z;
    logic [31:0] v2_x;
    logic [31:0] v2_y;
    logic [31:0] v2_z;
    modport source (output valid, scalar_v0, scalar_v1, scalar_v2, v0_x, v0_y, v0_z,
                    v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, input ready);
    modport sink (input valid, scalar_v0, scalar_v1, scalar_v2, v0_x, v0_y, v0_z,
                  v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, output ready);
endinterface

interface mti_seg_if;
    logic        valid;
    logic        ready;
    logic [31:0] start_x;
    logic [31:0] start_y;
    logic [31:0] start_z;
    logic [31:0] end_x;
    logic [31:0] end_y;
    logic [31:0] end_z;
    logic [1:0]  start_edge;
    logic [1:0]  end_edge;
    logic [2:0]  case_code;
    modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                    start_edge, end_edge, case_code, input ready);
    modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  start_edge, end_edge, case_code, output ready);
endinterface

FILE: design/marching_triangles_isoline.sv
// marching triangles isoline extractor, top level
// Accepts one triangle per cycle unless a stalled output holds tri_in.ready low, and returns
// at most one isoline segment for it. The 16-stage restoring divider forms the Q0.16
// interpolation fraction, one quotient bit per stage, after the input, edge setup and
// saturation check stages, followed by one multiply stage and one add stage. Triangles that
// lie wholly below or wholly at or above iso_level produce no transfer. Each stage advances
// on its own, so bubbles close up behind a stalled output. iso_level lies at byte address 0.
`include "assert_macros.svh"
module marching_triangles_isoline (
    input  logic                        clk,
    input  logic                        rst_n,
    mti_tri_if.sink                     tri_in,
    mti_seg_if.source                   seg_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mti_pkg::AddrW-1:0]   paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import mti_pkg::*;

    logic [31:0]        iso_level_reg;
    logic [NStages-1:0] v_reg;
    logic [NStages-1:0] en;
    tri_t               tri_reg;
    div_t               div_reg [1:StMul-1];
    mul_t               mul_reg;
    seg_t               seg_reg;
    tri_t               tri_next;
    logic               keep;

    // register port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ISO_LEVEL) ? iso_level_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iso_level_reg <= '0;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_ISO_LEVEL))
        begin
            iso_level_reg <= pwdata;
        end
    end

    // case code of the incoming triangle
    always_comb
    begin
        tri_next.s = {tri_in.scalar_v2, tri_in.scalar_v1, tri_in.scalar_v0};
        tri_next.p = {tri_in.v2_z, tri_in.v2_y, tri_in.v2_x,
                      tri_in.v1_z, tri_in.v1_y, tri_in.v1_x,
                      tri_in.v0_z, tri_in.v0_y, tri_in.v0_x};
        for (int i = 0; i < 3; i++) begin
            tri_next.code[i] = ($signed(tri_next.s[i]) >= $signed(iso_level_reg));
        end
        keep = (tri_next.code != 3'b000) && (tri_next.code != 3'b111);
    end

    // per-stage advance, a stage moves when empty or when its successor moves
    always_comb
    begin
        en[StOut] = !v_reg[StOut] || seg_out.ready;
        for (int i = StOut - 1; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign tri_in.ready = en[0];

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= tri_in.valid && keep;
            end
            for (int i = 1; i < NStages; i++) begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            tri_reg <= tri_next;
        end
        if (en[1])
        begin
            div_reg[1] <= edge_setup(tri_reg, iso_level_reg);
        end
        if (en[StInit])
        begin
            div_reg[StInit] <= div_init(div_reg[1]);
        end
        for (int k = StInit + 1; k < StMul; k++) begin
            if (en[k])
            begin
                div_reg[k] <= div_step(div_reg[k-1]);
            end
        end
        if (en[StMul])
        begin
            mul_reg <= interp_mul(div_reg[StMul-1]);
        end
        if (en[StOut])
        begin
            seg_reg.e0 <= mul_reg.e0;
            seg_reg.e1 <= mul_reg.e1;
            seg_reg.code <= mul_reg.code;
            for (int e = 0; e < 2; e++) begin
                for (int j = 0; j < 3; j++) begin
                    seg_reg.pt[e][j] <= mul_reg.pa[e][j] + mul_reg.off[e][j];
                end
            end
        end
    end

    // output transfer
    assign seg_out.valid      = v_reg[StOut];
    assign seg_out.start_x    = seg_reg.pt[0][0];
    assign seg_out.start_y    = seg_reg.pt[0][1];
    assign seg_out.start_z    = seg_reg.pt[0][2];
    assign seg_out.end_x      = seg_reg.pt[1][0];
    assign seg_out.end_y      = seg_reg.pt[1][1];
    assign seg_out.end_z      = seg_reg.pt[1][2];
    assign seg_out.start_edge = seg_reg.e0;
    assign seg_out.end_edge   = seg_reg.e1;
    assign seg_out.case_code  = seg_reg.code;

    // checks
    `ASSERT_HOLDS(a_code_mixed, clk, rst_n, !seg_out.valid || ((seg_out.case_code != 3'b000) && (seg_out.case_code != 3'b111)), "segment from uniform triangle")
    `ASSERT_HOLDS(a_edges_differ, clk, rst_n, !seg_out.valid || (seg_out.start_edge != seg_out.end_edge), "segment endpoints on one edge")
    `ASSERT_NEXT(a_enter, clk, rst_n, tri_in.valid && tri_in.ready && keep, v_reg[0], "crossing triangle not taken in")
    `ASSERT_NEXT(a_hold_stage, clk, rst_n, v_reg[1] && !en[1], v_reg[1] && $stable(div_reg[1]), "stalled stage lost its item")

endmodule

FILE: tb/mti_seg_checker.sv
// checker: predicts isoline segments from accepted triangles and compares them
module mti_seg_checker (
    input  logic        clk,
    input  logic        rst_n,
    mti_tri_if          tri_mon,
    mti_seg_if          seg_mon,
    input  logic [31:0] iso_level,
    output int          fail_count,
    output int          pending_count
);
    typedef struct {
        logic [31:0] pt [6];
        logic [1:0]  e0;
        logic [1:0]  e1;
        logic [2:0]  code;
    } segment_t;

    localparam logic [1:0] FIRST_EDGE [8] = '{mti_pkg::EDGE_01, mti_pkg::EDGE_01,
        mti_pkg::EDGE_12, mti_pkg::EDGE_12, mti_pkg::EDGE_20, mti_pkg::EDGE_01,
        mti_pkg::EDGE_20, mti_pkg::EDGE_01};
    localparam logic [1:0] SECOND_EDGE [8] = '{mti_pkg::EDGE_01, mti_pkg::EDGE_20,
        mti_pkg::EDGE_01, mti_pkg::EDGE_20, mti_pkg::EDGE_12, mti_pkg::EDGE_12,
        mti_pkg::EDGE_01, mti_pkg::EDGE_01};

    segment_t expected_segs [$];

    // endpoint on one crossed edge
    function automatic void edge_crossing(input logic [1:0] eg, input longint s [3],
                                          input longint p [3][3], input logic [31:0] lvl,
                                          output logic [31:0] pt [3]);
        int a;
        int b;
        longint num;
        longint den;
        longint t;
        longint prod;
        longint off;
        a = (eg == mti_pkg::EDGE_01) ? 0 : (eg == mti_pkg::EDGE_12) ? 1 : 2;
        b = (a + 1) % 3;
        num = longint'($signed(lvl)) - s[a];
        den = s[b] - s[a];
        if (num < 0) num = -num;
        if (den < 0) den = -den;
        t = 0;
        if (den != 0)
        begin
            t = (num * 65536) / den;
            if (t > 65535) t = 65535;
        end
        for (int j = 0; j < 3; j++)
        begin
            prod = t * (p[b][j] - p[a][j]);
            off = prod >>> 16;
            pt[j] = 32'(p[a][j] + off);
        end
    endfunction

    // predict segment from an accepted triangle
    function automatic void predict_segment(input logic [31:0] f [12], input logic [31:0] lvl);
        longint s [3];
        longint p [3][3];
        logic [2:0] code;
        logic [31:0] pa [3];
        logic [31:0] pb [3];
        segment_t sg;
        code = '0;
        for (int i = 0; i < 3; i++)
        begin
            s[i] = longint'($signed(f[i]));
            for (int j = 0; j < 3; j++) p[i][j] = longint'($signed(f[3 + i * 3 + j]));
            if (s[i] >= longint'($signed(lvl))) code[i] = 1'b1;
        end
        if (code == 3'd0 || code == 3'd7) return;
        edge_crossing(FIRST_EDGE[code], s, p, lvl, pa);
        edge_crossing(SECOND_EDGE[code], s, p, lvl, pb);
        for (int j = 0; j < 3; j++)
        begin
            sg.pt[j] = pa[j];
            sg.pt[3 + j] = pb[j];
        end
        sg.e0 = FIRST_EDGE[code];
        sg.e1 = SECOND_EDGE[code];
        sg.code = code;
        expected_segs.push_back(sg);
    endfunction

    // watch both channels at each rising edge
    always @(posedge clk)
    begin
        logic [31:0] f [12];
        logic [31:0] got [6];
        segment_t ex;
        if (rst_n)
        begin
            if (seg_mon.valid && seg_mon.ready)
            begin
                got = '{seg_mon.start_x, seg_mon.start_y, seg_mon.start_z,
                        seg_mon.end_x, seg_mon.end_y, seg_mon.end_z};
                if (expected_segs.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected segment transfer, expected none, got case %0d",
                             $time, seg_mon.case_code);
                end
                else
                begin
                    ex = expected_segs.pop_front();
                    for (int k = 0; k < 6; k++)
                        if (got[k] !== ex.pt[k])
                        begin
                            fail_count++;
                            $display("%0t: coordinate %0d expected %h got %h",
                                     $time, k, ex.pt[k], got[k]);
                        end
                    if (seg_mon.start_edge !== ex.e0 || seg_mon.end_edge !== ex.e1 ||
                        seg_mon.case_code !== ex.code)
                    begin
                        fail_count++;
                        $display("%0t: edges/case expected %0d %0d %0d got %0d %0d %0d",
                                 $time, ex.e0, ex.e1, ex.code, seg_mon.start_edge,
                                 seg_mon.end_edge, seg_mon.case_code);
                    end
                end
            end
            if (tri_mon.valid && tri_mon.ready)
            begin
                f = '{tri_mon.scalar_v0, tri_mon.scalar_v1, tri_mon.scalar_v2,
                      tri_mon.v0_x, tri_mon.v0_y, tri_mon.v0_z, tri_mon.v1_x, tri_mon.v1_y,
                      tri_mon.v1_z, tri_mon.v2_x, tri_mon.v2_y, tri_mon.v2_z};
                predict_segment(f, iso_level);
            end
            pending_count = expected_segs.size();
        end
    end

    initial
    begin
        fail_count = 0;
        pending_count = 0;
    end
endmodule

FILE: tb/tb_top.sv
// testbench top: clock, reset, triangle stimulus, register writes and verdict
module tb_top;
    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [mti_pkg::AddrW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic [31:0] cur_level;
    int          fail_count;
    int          pending_count;

    mti_tri_if tri_ch ();
    mti_seg_if seg_ch ();

    marching_triangles_isoline i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .tri_in  (tri_ch.sink),
        .seg_out (seg_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    mti_seg_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .tri_mon       (tri_ch),
        .seg_mon       (seg_ch),
        .iso_level     (cur_level),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // mostly short gaps, a few long ones, some stretches with none
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // register write: setup then access
    task automatic write_level(input logic [31:0] v);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= mti_pkg::AddrW'(mti_pkg::REG_ISO_LEVEL) << 2;
        pwdata <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        cur_level = v;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // one triangle transfer with a random gap ahead of it, valid stays up afterwards
    task automatic send_tri(input logic [31:0] f [12]);
        int g;
        g = gap_len();
        if (g != 0)
        begin
            tri_ch.valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        tri_ch.valid <= 1'b1;
        {tri_ch.scalar_v0, tri_ch.scalar_v1, tri_ch.scalar_v2} <= {f[0], f[1], f[2]};
        {tri_ch.v0_x, tri_ch.v0_y, tri_ch.v0_z} <= {f[3], f[4], f[5]};
        {tri_ch.v1_x, tri_ch.v1_y, tri_ch.v1_z} <= {f[6], f[7], f[8]};
        {tri_ch.v2_x, tri_ch.v2_y, tri_ch.v2_z} <= {f[9], f[10], f[11]};
        do @(posedge clk); while (!tri_ch.ready);
        @(negedge clk);
    endtask

    // random 32-bit value biased to extremes and near the level
    function automatic logic [31:0] pick_val(input logic [31:0] lvl);
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return lvl;
            3: return lvl + 32'($signed($urandom_range(0, 512)) - 256);
            4: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
            default: return $urandom();
        endcase
    endfunction

    // stop sending and wait out the pipeline before a register write
    task automatic drain();
        tri_ch.valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    // output stall pattern
    initial
    begin
        int g;
        seg_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            seg_ch.ready <= 1'b1;
            g = gap_len();
            if (g != 0)
            begin
                @(negedge clk);
                seg_ch.ready <= 1'b0;
                repeat (g - 1) @(negedge clk);
            end
            else
                repeat ($urandom_range(0, 6)) @(negedge clk);
        end
    end

    initial
    begin
        #40_000_000;
        $display("simulation failed");
        $finish;
    end

    // stimulus and verdict
    initial
    begin
        logic [31:0] f [12];
        logic [31:0] levels [6];
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cur_level = '0;
        tri_ch.valid = 1'b0;
        {tri_ch.scalar_v0, tri_ch.scalar_v1, tri_ch.scalar_v2} = '0;
        {tri_ch.v0_x, tri_ch.v0_y, tri_ch.v0_z, tri_ch.v1_x, tri_ch.v1_y} = '0;
        {tri_ch.v1_z, tri_ch.v2_x, tri_ch.v2_y, tri_ch.v2_z} = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: every case code at the reset level
        for (int c = 0; c < 8; c++)
        begin
            for (int i = 0; i < 3; i++)
                f[i] = c[i] ? 32'h0001_0000 * (i + 1) : -32'h0001_0000 * (i + 1);
            for (int k = 3; k < 12; k++) f[k] = 32'($signed(k * 70000) - 400000);
            send_tri(f);
        end
        // level equal to far scalar, extreme scalars and coordinates
        f = '{32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
              32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h8000_0000,
              32'h7fff_ffff, 32'h1};
        send_tri(f);
        f = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h7fff_ffff, 32'h8000_0000,
              32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h7fff_ffff,
              32'h8000_0000, 32'h1};
        send_tri(f);
        f = '{32'hffff_ffff, 32'h0, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff,
              32'hffff_ffff, 32'h0, 32'h0, 32'h0, 32'hffff_ffff, 32'h0, 32'hffff_ffff};
        send_tri(f);
        drain();

        levels = '{32'h8000_0000, 32'h7fff_ffff, 32'h0001_8000, 32'hfffe_0000,
                   $urandom(), 32'h0};
        for (int ph = 0; ph < 6; ph++)
        begin
            write_level(levels[ph]);
            // every level but the most negative: one directed straddle item each
            for (int i = 0; i < 3; i++) f[i] = (i == 0) ? levels[ph] : levels[ph] - 1;
            for (int k = 3; k < 12; k++) f[k] = $urandom();
            if (levels[ph] != 32'h8000_0000) send_tri(f);
            for (int n = 0; n < 290; n++)
            begin
                for (int i = 0; i < 3; i++) f[i] = pick_val(levels[ph]);
                for (int k = 3; k < 12; k++) f[k] = ($urandom_range(0, 3) == 0) ?
                    pick_val(32'h0) : 32'($signed($urandom_range(0, 200 << 16)) -
                    (100 << 16));
                send_tri(f);
            end
            drain();
        end

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+design
design/mti_pkg.sv
design/mti_ifs.sv
design/marching_triangles_isoline.sv
tb/mti_seg_checker.sv
tb/tb_top.sv
